### hdl/c2p_pkg.sv
// Shared constants, lane type and arctangent table of the Cartesian-to-polar converter.
package c2p_pkg;

  localparam int unsigned SAMPLE_WIDTH    = 16;
  localparam int unsigned ROTATION_STAGES = 16;

  localparam int unsigned GUARD_BITS = 16;
  localparam int unsigned ANGLE_FRAC = 24;
  localparam int unsigned OUT_FRAC   = 13;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned SPLIT_BITS = 25;
  localparam int unsigned GAIN_W     = 30;

  // Three spare bits cover the fold to the right half plane and the CORDIC growth.
  localparam int unsigned DATA_W     = SAMPLE_WIDTH + GUARD_BITS + 3;
  localparam int unsigned Z_W        = ANGLE_FRAC + 5;
  localparam int unsigned IDX_W      = $clog2(ROTATION_STAGES);
  localparam int unsigned ATAN_IDX_W = 5;

  localparam logic signed [Z_W-1:0]     PI_FINE  = Z_W'(52707179);
  localparam logic signed [ANGLE_W-1:0] PI_OUT   = ANGLE_W'(25736);
  localparam logic [GAIN_W-1:0]         INV_GAIN = GAIN_W'(652032874);

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [Z_W-1:0]    z;
    logic                     origin;
    logic                     neg_axis;
  } c2p_lane_t;

  // Elementary angles atan(2^-i) in units of 2^-24 rad.
  function automatic logic signed [Z_W-1:0] atan_fine(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    unique case (idx)
      5'd0:    val = Z_W'(13176795);
      5'd1:    val = Z_W'(7778716);
      5'd2:    val = Z_W'(4110060);
      5'd3:    val = Z_W'(2086331);
      5'd4:    val = Z_W'(1047214);
      5'd5:    val = Z_W'(524117);
      5'd6:    val = Z_W'(262123);
      5'd7:    val = Z_W'(131069);
      5'd8:    val = Z_W'(65536);
      5'd9:    val = Z_W'(32768);
      5'd10:   val = Z_W'(16384);
      5'd11:   val = Z_W'(8192);
      5'd12:   val = Z_W'(4096);
      5'd13:   val = Z_W'(2048);
      5'd14:   val = Z_W'(1024);
      5'd15:   val = Z_W'(512);
      5'd16:   val = Z_W'(256);
      5'd17:   val = Z_W'(128);
      5'd18:   val = Z_W'(64);
      5'd19:   val = Z_W'(32);
      5'd20:   val = Z_W'(16);
      5'd21:   val = Z_W'(8);
      5'd22:   val = Z_W'(4);
      5'd23:   val = Z_W'(2);
      5'd24:   val = Z_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### hdl/c2p_coord_if.sv
// Handshake channel that carries one Cartesian point per item.
interface c2p_coord_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [c2p_pkg::SAMPLE_WIDTH-1:0] x_coord;
  logic signed [c2p_pkg::SAMPLE_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

### hdl/c2p_polar_if.sv
// Handshake channel that carries one polar result per item.
interface c2p_polar_if;
  logic                                valid;
  logic                                ready;
  logic [c2p_pkg::SAMPLE_WIDTH-1:0]    magnitude;
  logic signed [c2p_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, output magnitude, output angle, input ready);
  modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

### hdl/cartesian_to_polar_unit.sv
// Top level of the CORDIC Cartesian-to-polar converter.
//
// The unit takes one signed point (x_coord, y_coord) per item and returns
// its magnitude sqrt(x*x + y*y), unsigned in the input's units with the
// CORDIC gain removed, and its angle atan2(y, x) as signed Q3.13 radians
// between minus pi and pi, both rounded to nearest. The origin gives
// magnitude 0 and angle 0, and a point on the negative x axis gives +pi.
// The unit accepts a new item in every cycle. Each item passes through
// the pipeline registers in order: one register per vectoring cell, one
// for the gain multiplication and one output register. Every stage holds
// its item while the stage after it is full, so stalls on the result side
// fill the empty stages first and only then hold off new items. The unit
// keeps no state between items.
module cartesian_to_polar_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2p_coord_if.sink   coord_i,
  c2p_polar_if.source polar_o
);

  localparam int unsigned NS = c2p_pkg::ROTATION_STAGES;

  // Handshake and data links along the chain; link 0 is the folded input.
  logic               link_valid [NS+1];
  logic               link_ready [NS+1];
  c2p_pkg::c2p_lane_t link_lane  [NS+1];

  logic signed [c2p_pkg::DATA_W-1:0] x_ext, y_ext;
  logic                              x_neg, y_zero;

  // Fold a left half plane point by pi so that the cells only see x >= 0,
  // then scale by the guard bits.
  always_comb begin
    x_neg  = coord_i.x_coord[c2p_pkg::SAMPLE_WIDTH-1];
    y_zero = (coord_i.y_coord == '0);
    x_ext  = c2p_pkg::DATA_W'(coord_i.x_coord);
    y_ext  = c2p_pkg::DATA_W'(coord_i.y_coord);

    link_lane[0].origin   = (coord_i.x_coord == '0) && y_zero;
    link_lane[0].neg_axis = x_neg && y_zero;
    if (x_neg) begin
      link_lane[0].x = (-x_ext) <<< c2p_pkg::GUARD_BITS;
      link_lane[0].y = (-y_ext) <<< c2p_pkg::GUARD_BITS;
      link_lane[0].z = coord_i.y_coord[c2p_pkg::SAMPLE_WIDTH-1] ?
                       -c2p_pkg::PI_FINE : c2p_pkg::PI_FINE;
    end else begin
      link_lane[0].x = x_ext <<< c2p_pkg::GUARD_BITS;
      link_lane[0].y = y_ext <<< c2p_pkg::GUARD_BITS;
      link_lane[0].z = '0;
    end
  end

  assign link_valid[0] = coord_i.valid;
  assign coord_i.ready = link_ready[0];

  for (genvar g = 0; g < NS; g++) begin : g_cell
    c2p_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (c2p_pkg::IDX_W'(g)),
      .valid_i (link_valid[g]),
      .lane_i  (link_lane[g]),
      .ready_o (link_ready[g]),
      .valid_o (link_valid[g+1]),
      .lane_o  (link_lane[g+1]),
      .ready_i (link_ready[g+1])
    );
  end

  c2p_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[NS]),
    .lane_i  (link_lane[NS]),
    .ready_o (link_ready[NS]),
    .polar_o (polar_o)
  );

endmodule

### hdl/c2p_cell.sv
// One CORDIC vectoring stage with its own pipeline register.
module c2p_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [c2p_pkg::IDX_W-1:0]       stage_i,
  input  logic                            valid_i,
  input  c2p_pkg::c2p_lane_t              lane_i,
  output logic                            ready_o,
  output logic                            valid_o,
  output c2p_pkg::c2p_lane_t              lane_o,
  input  logic                            ready_i
);

  logic                            valid_q;
  c2p_pkg::c2p_lane_t              lane_d, lane_q;
  logic signed [c2p_pkg::DATA_W-1:0] dx, dy;
  logic signed [c2p_pkg::Z_W-1:0]    step_angle;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx         = lane_i.y >>> stage_i;
    dy         = lane_i.x >>> stage_i;
    step_angle = c2p_pkg::atan_fine(c2p_pkg::ATAN_IDX_W'(stage_i));
    lane_d     = lane_i;
    // Rotate toward the x axis: the sign of y picks the direction.
    if (!lane_i.y[c2p_pkg::DATA_W-1]) begin
      lane_d.x = lane_i.x + dx;
      lane_d.y = lane_i.y - dy;
      lane_d.z = lane_i.z + step_angle;
    end else begin
      lane_d.x = lane_i.x - dx;
      lane_d.y = lane_i.y + dy;
      lane_d.z = lane_i.z - step_angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

### hdl/c2p_post.sv
// Gain compensation of the magnitude and rounding of the angle, two register stages.
module c2p_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  c2p_pkg::c2p_lane_t lane_i,
  output logic               ready_o,
  c2p_polar_if.source        polar_o
);

  localparam int unsigned HI_W     = c2p_pkg::DATA_W - c2p_pkg::SPLIT_BITS;
  localparam int unsigned HP_W     = HI_W + c2p_pkg::GAIN_W;
  localparam int unsigned LP_W     = c2p_pkg::SPLIT_BITS + c2p_pkg::GAIN_W;
  localparam int unsigned R_W      = HP_W + 1;
  localparam int unsigned ROUND_SH = 30 + c2p_pkg::GUARD_BITS - c2p_pkg::SPLIT_BITS;
  localparam int unsigned MAG_W    = R_W + 1 - ROUND_SH;
  localparam int unsigned ANG_SH   = c2p_pkg::ANGLE_FRAC - c2p_pkg::OUT_FRAC;

  localparam logic signed [c2p_pkg::Z_W-1:0] ANG_RND = c2p_pkg::Z_W'(1) << (ANG_SH - 1);
  localparam logic signed [c2p_pkg::Z_W-1:0] PI_OUT_Z = c2p_pkg::Z_W'(c2p_pkg::PI_OUT);
  localparam logic [R_W:0] MAG_RND = (R_W + 1)'(1) << (ROUND_SH - 1);

  // First stage: partial products and the rounded angle.
  logic                                  s1_valid_q, s1_ready;
  logic [HP_W-1:0]                       hi_prod_d, hi_prod_q;
  logic [c2p_pkg::GAIN_W-1:0]            lo_prod_d, lo_prod_q;
  logic [LP_W-1:0]                       lo_full;
  logic [c2p_pkg::DATA_W-1:0]            ux;
  logic signed [c2p_pkg::Z_W-1:0]        z_rnd, aq;
  logic signed [c2p_pkg::ANGLE_W-1:0]    angle_d, s1_angle_q;
  logic                                  s1_origin_q;

  // Second stage: the output register.
  logic                                  out_valid_q, out_ready;
  logic [R_W:0]                          r_sum;
  logic [MAG_W-1:0]                      mag_full;
  logic [c2p_pkg::SAMPLE_WIDTH-1:0]      mag_d, mag_q;
  logic signed [c2p_pkg::ANGLE_W-1:0]    out_angle_q;

  assign out_ready = !out_valid_q || polar_o.ready;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign ready_o   = s1_ready;

  always_comb begin
    ux        = lane_i.x[c2p_pkg::DATA_W-1] ? '0 : lane_i.x;
    hi_prod_d = HP_W'(ux[c2p_pkg::DATA_W-1:c2p_pkg::SPLIT_BITS]) * HP_W'(c2p_pkg::INV_GAIN);
    lo_full   = LP_W'(ux[c2p_pkg::SPLIT_BITS-1:0]) * LP_W'(c2p_pkg::INV_GAIN);
    lo_prod_d = lo_full[LP_W-1:c2p_pkg::SPLIT_BITS];

    z_rnd = lane_i.z + ANG_RND;
    aq    = z_rnd >>> ANG_SH;
    if (lane_i.origin) begin
      angle_d = '0;
    end else if (lane_i.neg_axis || aq > PI_OUT_Z) begin
      angle_d = c2p_pkg::PI_OUT;
    end else if (aq < -PI_OUT_Z) begin
      angle_d = -c2p_pkg::PI_OUT;
    end else begin
      angle_d = c2p_pkg::ANGLE_W'(aq);
    end
  end

  always_comb begin
    r_sum    = (R_W + 1)'(hi_prod_q) + (R_W + 1)'(lo_prod_q) + MAG_RND;
    mag_full = r_sum[R_W:ROUND_SH];
    if (s1_origin_q) begin
      mag_d = '0;
    end else if (|mag_full[MAG_W-1:c2p_pkg::SAMPLE_WIDTH]) begin
      mag_d = '1;
    end else begin
      mag_d = mag_full[c2p_pkg::SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      hi_prod_q   <= hi_prod_d;
      lo_prod_q   <= lo_prod_d;
      s1_angle_q  <= angle_d;
      s1_origin_q <= lane_i.origin;
    end
    if (out_ready && s1_valid_q) begin
      mag_q       <= mag_d;
      out_angle_q <= s1_angle_q;
    end
  end

  assign polar_o.valid     = out_valid_q;
  assign polar_o.magnitude = mag_q;
  assign polar_o.angle     = out_angle_q;

endmodule

### hdl/c2p_checker.sv
// Port checker of the Cartesian-to-polar converter and its bind statement.
module c2p_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     polar_valid_i,
  input logic                                     polar_ready_i,
  input logic [c2p_pkg::SAMPLE_WIDTH-1:0]         magnitude_i,
  input logic signed [c2p_pkg::ANGLE_W-1:0]       angle_i
);

  // A result that is not taken stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_valid_i && !polar_ready_i |=> polar_valid_i)
    else $error("result item withdrawn before it was taken");

  // A stalled result keeps its payload.
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_valid_i && !polar_ready_i |=> $stable(magnitude_i) && $stable(angle_i))
    else $error("result item changed while stalled");

  // The angle never leaves the range minus pi to pi.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_valid_i |-> (angle_i <= c2p_pkg::PI_OUT) && (angle_i >= -c2p_pkg::PI_OUT))
    else $error("angle outside minus pi to pi");

  // Only the origin rounds to a zero magnitude, and it carries a zero angle.
  a_origin_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_valid_i && (magnitude_i == '0) |-> (angle_i == '0))
    else $error("zero magnitude with a nonzero angle");

endmodule

bind cartesian_to_polar_unit c2p_checker u_c2p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .polar_valid_i (polar_o.valid),
  .polar_ready_i (polar_o.ready),
  .magnitude_i   (polar_o.magnitude),
  .angle_i       (polar_o.angle)
);
